[src/clpts_pkg.sv]
// Shared types and constants for the camera and light pulse-train sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package clpts_pkg;

  localparam int MAX_PULSES_DEF = 4;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [14:0] PERIOD_MIN   = 15'd4;
  localparam logic [14:0] PERIOD_RESET = 15'd1000;
  localparam logic [14:0] WIDTH_RESET  = 15'd1000;
  localparam logic [15:0] OVT_MAX      = 16'hFFFF;

  localparam logic [3:0] ROUTE_CAMERA     = 4'd0;
  localparam logic [3:0] ROUTE_LIGHT_LAST = 4'd4;
  localparam logic [3:0] ROUTE_BOTH_FIRST = 4'd5;
  localparam logic [3:0] ROUTE_BOTH_LAST  = 4'd8;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_FREE,
    SRC_TIMED,
    SRC_HW_TTL,
    SRC_HW_DIFF,
    SRC_ENCODER
  } src_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE,
    REG_PERIOD,
    REG_LENGTH,
    REG_ROUTE,
    REG_WIDTH0,
    REG_WIDTH1,
    REG_WIDTH2,
    REG_WIDTH3
  } reg_idx_t;

  typedef struct packed {
    src_t             source;
    logic [14:0]      period;
    logic [2:0]       length;
    logic [15:0]      route;
    logic [3:0][14:0] width;
  } cfg_t;

  typedef struct packed {
    logic cam_rise;
    logic ext;
    logic clr;
  } item_t;

  typedef struct packed {
    logic        camera_pulse;
    logic        light_pulse;
    logic [1:0]  light_select;
    logic [2:0]  pulse_number;
    logic        train_busy;
    logic        trigger_accepted;
    logic        trigger_rejected;
    logic [15:0] overtrigger_total;
  } result_t;

endpackage

`default_nettype wire

[src/camera_light_pulse_train_sequencer_core.sv]
// Top level of the camera and light pulse-train sequencer: input and result registers,
// handshakes, configuration port. Depends on clpts_pkg, clpts_cfg and clpts_core.
//
// Each transaction on the item channel is one 1 us tick with its event flags and gives
// exactly one result transaction. The block takes one item per clock cycle; a result is
// offered from the result register after its item has passed through the item register
// and the combinational step. The result register lets the next item be taken while a
// result waits, so throughput stays at one item per cycle until result_stall holds the
// result register full and the item register is occupied. Configuration writes take
// effect at once; a write to the trigger source stops the timer and ends the train.
`default_nettype none

module camera_light_pulse_train_sequencer_core #(
  parameter int MAX_PULSES = clpts_pkg::MAX_PULSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [clpts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clpts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              camera_ready_rise,
  input  logic                              ext_trigger,
  input  logic                              clear_overtrigger,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              camera_pulse,
  output logic                              light_pulse,
  output logic [1:0]                        light_select,
  output logic [2:0]                        pulse_number,
  output logic                              train_busy,
  output logic                              trigger_accepted,
  output logic                              trigger_rejected,
  output logic [15:0]                       overtrigger_total
);
  import clpts_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t step_res, res_q;
  logic    item_full, res_full;
  logic    advance, item_take, restart;

  assign restart   = cfg_write && (reg_idx_t'(cfg_index) == REG_SOURCE);
  assign advance   = item_full && (!res_full || !result_stall);
  assign item_stall = item_full && !advance;
  assign item_take = item_valid && !item_stall;

  clpts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clpts_core #(
    .MAX_PULSES (MAX_PULSES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (advance),
    .item    (item_q),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
      res_full  <= 1'b0;
    end else begin
      if (item_take) begin
        item_full <= 1'b1;
      end else if (advance) begin
        item_full <= 1'b0;
      end
      if (advance) begin
        res_full <= 1'b1;
      end else if (!result_stall) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_q.cam_rise <= camera_ready_rise;
      item_q.ext      <= ext_trigger;
      item_q.clr      <= clear_overtrigger;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign result_valid      = res_full;
  assign camera_pulse      = res_q.camera_pulse;
  assign light_pulse       = res_q.light_pulse;
  assign light_select      = res_q.light_select;
  assign pulse_number      = res_q.pulse_number;
  assign train_busy        = res_q.train_busy;
  assign trigger_accepted  = res_q.trigger_accepted;
  assign trigger_rejected  = res_q.trigger_rejected;
  assign overtrigger_total = res_q.overtrigger_total;

endmodule

`default_nettype wire

[src/clpts_cfg.sv]
// Configuration register file: source, timed period, train length, routes, widths.
// Depends on clpts_pkg.
`default_nettype none

module clpts_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [clpts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clpts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output clpts_pkg::cfg_t                   cfg
);
  import clpts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source <= SRC_NONE;
      cfg.period <= PERIOD_RESET;
      cfg.length <= 3'd1;
      cfg.route  <= '0;
      cfg.width  <= {4{WIDTH_RESET}};
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_SOURCE: begin
          cfg.source <= (cfg_data[2:0] <= 3'(SRC_ENCODER)) ? src_t'(cfg_data[2:0]) : SRC_NONE;
        end
        REG_PERIOD: begin
          if (cfg_data[14:0] >= PERIOD_MIN) begin
            cfg.period <= cfg_data[14:0];
          end
        end
        REG_LENGTH: cfg.length   <= cfg_data[2:0];
        REG_ROUTE:  cfg.route    <= cfg_data;
        REG_WIDTH0: cfg.width[0] <= cfg_data[14:0];
        REG_WIDTH1: cfg.width[1] <= cfg_data[14:0];
        REG_WIDTH2: cfg.width[2] <= cfg_data[14:0];
        REG_WIDTH3: cfg.width[3] <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/clpts_core.sv]
// Sequencer state and the per-tick step: triggers, pulse starts, timer and outputs.
// Depends on clpts_pkg; configuration comes from clpts_cfg.
`default_nettype none

module clpts_core #(
  parameter int MAX_PULSES = clpts_pkg::MAX_PULSES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  clpts_pkg::cfg_t    cfg,
  input  logic               restart,
  input  logic               step,
  input  clpts_pkg::item_t   item,
  output clpts_pkg::result_t result
);
  import clpts_pkg::*;

  localparam int NP_W  = $clog2(MAX_PULSES + 1);
  localparam int LEN_W = (NP_W > 3) ? NP_W : 3;

  logic            timer_running, timer_running_next;
  logic [14:0]     width_left, width_left_next;
  logic [NP_W-1:0] next_pulse, next_pulse_next;
  logic            train_done, train_done_next;
  logic [3:0]      active_route, active_route_next;
  logic [15:0]     dropped_count, dropped_count_next;
  logic [14:0]     timed_ticks, timed_ticks_next;

  logic [LEN_W-1:0] len_ext, eff_len;
  logic             free_mode, timed_mode, ext_mode;
  logic             start_cam, timed_hit, fire_req, fire_ok, begin_pulse;
  logic [15:0]      tick_inc, dropped_clr;
  logic [NP_W-1:0]  np_base, np_inc;
  logic [1:0]       idx;
  logic [3:0]       code;
  logic             tr_mid, high;
  logic [14:0]      wl_mid;

  always_comb begin
    len_ext = LEN_W'(cfg.length);
    if (len_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > LEN_W'(MAX_PULSES)) begin
      eff_len = LEN_W'(MAX_PULSES);
    end else begin
      eff_len = len_ext;
    end

    free_mode  = (cfg.source == SRC_FREE);
    timed_mode = (cfg.source == SRC_TIMED);
    ext_mode   = (cfg.source == SRC_HW_TTL) || (cfg.source == SRC_HW_DIFF) ||
                 (cfg.source == SRC_ENCODER);

    // camera-ready either continues an open train or, in free run, starts one
    start_cam = item.cam_rise && (!train_done || free_mode);
    tick_inc  = {1'b0, timed_ticks} + 16'd1;
    timed_hit = timed_mode && (tick_inc >= {1'b0, cfg.period});
    fire_req  = timed_hit || (item.ext && ext_mode);
    fire_ok   = fire_req && !start_cam && train_done && !(timer_running && !item.cam_rise);
    begin_pulse = start_cam || fire_ok;

    np_base = (start_cam && !train_done) ? next_pulse : '0;
    np_inc  = np_base + NP_W'(1);
    idx     = 2'(np_base);
    code    = cfg.route[{idx, 2'b00} +: 4];

    dropped_clr = item.clr ? '0 : dropped_count;
    dropped_count_next = (fire_req && !fire_ok && dropped_clr != OVT_MAX) ?
                         dropped_clr + 16'd1 : dropped_clr;

    tr_mid = begin_pulse ? 1'b1 : (item.cam_rise ? 1'b0 : timer_running);
    wl_mid = begin_pulse ? cfg.width[idx] : width_left;
    active_route_next = (begin_pulse && code <= ROUTE_BOTH_LAST) ? code : active_route;
    next_pulse_next   = begin_pulse ? np_inc : next_pulse;
    train_done_next   = begin_pulse ? (LEN_W'(np_inc) >= eff_len) : train_done;

    high = tr_mid && (wl_mid != '0);
    timer_running_next = tr_mid;
    width_left_next    = high ? wl_mid - 15'd1 : wl_mid;

    if (!timed_mode || timed_hit) begin
      timed_ticks_next = '0;
    end else begin
      timed_ticks_next = tick_inc[14:0];
    end

    result.camera_pulse = high && ((active_route_next == ROUTE_CAMERA) ||
                                   (active_route_next > ROUTE_LIGHT_LAST));
    result.light_pulse  = high && (active_route_next != ROUTE_CAMERA);
    if (active_route_next == ROUTE_CAMERA) begin
      result.light_select = 2'd0;
    end else if (active_route_next <= ROUTE_LIGHT_LAST) begin
      result.light_select = 2'(active_route_next - 4'd1);
    end else begin
      result.light_select = 2'(active_route_next - ROUTE_BOTH_FIRST);
    end
    result.pulse_number      = 3'(next_pulse_next);
    result.train_busy        = !train_done_next || timer_running_next;
    result.trigger_accepted  = (start_cam && train_done) || fire_ok;
    result.trigger_rejected  = fire_req && !fire_ok;
    result.overtrigger_total = dropped_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_running <= 1'b0;
      width_left    <= '0;
      next_pulse    <= '0;
      train_done    <= 1'b1;
      active_route  <= '0;
      dropped_count <= '0;
      timed_ticks   <= '0;
    end else if (restart) begin
      timer_running <= 1'b0;
      width_left    <= '0;
      train_done    <= 1'b1;
      timed_ticks   <= '0;
    end else if (step) begin
      timer_running <= timer_running_next;
      width_left    <= width_left_next;
      next_pulse    <= next_pulse_next;
      train_done    <= train_done_next;
      active_route  <= active_route_next;
      dropped_count <= dropped_count_next;
      timed_ticks   <= timed_ticks_next;
    end
  end

endmodule

`default_nettype wire
